// ----- design/spm_pkg.sv -----
package spm_pkg;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam int COEF_WIDTH = 32;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_SAT    = 3'd3,
        ST_CANCEL = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_SEARCH,
        CMD_UPDATE,
        CMD_REMOVE,
        CMD_INSERT,
        CMD_ROTATE
    } cell_cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_MATCH,
        S_APPLY,
        S_RESP,
        S_READ
    } state_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [15:0]       term_exponent;
        logic signed [31:0] term_coefficient;
    } req_t;

    typedef struct packed {
        logic [15:0]        out_exponent;
        logic signed [31:0] out_coefficient;
        logic               last_term;
        status_t            status;
    } rsp_t;

    typedef struct packed {
        cell_cmd_t          cmd;
        logic signed [31:0] coef;
    } cell_ctrl_t;

endpackage

// ----- design/spm_stream_if.sv -----
interface spm_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- design/spm_cell.sv -----
module spm_cell
    import spm_pkg::*;
#(
    parameter int EXP_WIDTH = 16
) (
    input  logic                  clk,
    input  cell_ctrl_t            ctrl,
    input  logic [EXP_WIDTH-1:0]  bcast_exp,
    input  logic                  valid,
    input  logic [EXP_WIDTH-1:0]  left_exp,
    input  logic signed [31:0]    left_coef,
    input  logic                  left_lt,
    input  logic [EXP_WIDTH-1:0]  right_exp,
    input  logic signed [31:0]    right_coef,
    output logic [EXP_WIDTH-1:0]  exp,
    output logic signed [31:0]    coef,
    output logic                  lt,
    output logic                  hit,
    output logic [31:0]           hit_coef
);

    logic [EXP_WIDTH-1:0] exp_reg;
    logic signed [31:0]   coef_reg;
    logic                 lt_reg;
    logic                 eq_reg;

    always_ff @(posedge clk)
    begin
        case (ctrl.cmd)
            CMD_SEARCH:
            begin
                lt_reg <= valid && (exp_reg < bcast_exp);
                eq_reg <= valid && (exp_reg == bcast_exp);
            end
            CMD_UPDATE:
            begin
                if (eq_reg)
                begin
                    coef_reg <= ctrl.coef;
                end
            end
            CMD_REMOVE:
            begin
                if (!lt_reg)
                begin
                    exp_reg  <= right_exp;
                    coef_reg <= right_coef;
                end
            end
            CMD_INSERT:
            begin
                if (!lt_reg)
                begin
                    if (left_lt)
                    begin
                        exp_reg  <= bcast_exp;
                        coef_reg <= ctrl.coef;
                    end
                    else
                    begin
                        exp_reg  <= left_exp;
                        coef_reg <= left_coef;
                    end
                end
            end
            CMD_ROTATE:
            begin
                exp_reg  <= right_exp;
                coef_reg <= right_coef;
            end
            default:
            begin
            end
        endcase
    end

    assign exp      = exp_reg;
    assign coef     = coef_reg;
    assign lt       = lt_reg;
    assign hit      = eq_reg;
    assign hit_coef = eq_reg ? coef_reg : 32'd0;

endmodule

// ----- design/sparse_polynomial_term_merger.sv -----
// channel  dir  beat payload                                        handshake
// req      in   operation, term_exponent, term_coefficient          valid/ready
// rsp      out  out_exponent, out_coefficient, last_term, status    valid/ready
//
// clear goes straight to the response; add goes through the search, match select and apply steps
// read out rotates the whole cell ring, one term per beat
// read out of an empty table goes straight to the response with status ST_EMPTY
// a new request is taken only once the previous one is finished
// rsp stalls hold the sequencer; one result waits in the output register
// rst_n clears the term count and control; cell contents are don't-care until written
module sparse_polynomial_term_merger
    import spm_pkg::*;
#(
    parameter int MAX_TERMS = 32,
    parameter int EXP_WIDTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    spm_stream_if.sink   req,
    spm_stream_if.source rsp
);

    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam int KW = $clog2(MAX_TERMS);

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [KW-1:0]        k_reg, k_next;
    logic [1:0]           op_reg;
    logic [EXP_WIDTH-1:0] e_reg;
    logic signed [31:0]   c_reg;
    logic signed [31:0]   match_reg;
    logic                 any_reg;
    status_t              status_reg, status_next;
    rsp_t                 out_reg, out_next;
    logic                 out_valid_reg;
    logic                 out_load;
    logic                 slot_free;
    logic                 accept;

    cell_ctrl_t           ctrl;
    logic [EXP_WIDTH-1:0] cell_exp [MAX_TERMS];
    logic signed [31:0]   cell_coef [MAX_TERMS];
    logic [MAX_TERMS-1:0] cell_lt;
    logic [MAX_TERMS-1:0] cell_hit;
    logic [31:0]          cell_hit_coef [MAX_TERMS];
    logic [MAX_TERMS-1:0] cell_valid;
    logic [31:0]          hit_or;

    logic [EXP_WIDTH+15:0] in_exp_wide;
    logic [EXP_WIDTH+15:0] out_exp_wide;
    logic signed [32:0]    sum;

    assign in_exp_wide  = {{EXP_WIDTH{1'b0}}, req.data.term_exponent};
    assign out_exp_wide = {16'd0, cell_exp[0]};

    genvar g;
    generate
        for (g = 0; g < MAX_TERMS; g++)
        begin : g_cell
            logic [EXP_WIDTH-1:0] l_exp;
            logic signed [31:0]   l_coef;
            logic                 l_lt;
            logic [EXP_WIDTH-1:0] r_exp;
            logic signed [31:0]   r_coef;

            assign cell_valid[g] = (count_reg > CW'(g));

            if (g == 0)
            begin : g_first
                assign l_exp  = '0;
                assign l_coef = '0;
                assign l_lt   = 1'b1;
            end
            else
            begin : g_mid
                assign l_exp  = cell_exp[g-1];
                assign l_coef = cell_coef[g-1];
                assign l_lt   = cell_lt[g-1];
            end

            if (g == MAX_TERMS - 1)
            begin : g_last
                assign r_exp  = cell_exp[0];
                assign r_coef = cell_coef[0];
            end
            else
            begin : g_inner
                assign r_exp  = cell_exp[g+1];
                assign r_coef = cell_coef[g+1];
            end

            spm_cell #(
                .EXP_WIDTH (EXP_WIDTH)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .bcast_exp  (e_reg),
                .valid      (cell_valid[g]),
                .left_exp   (l_exp),
                .left_coef  (l_coef),
                .left_lt    (l_lt),
                .right_exp  (r_exp),
                .right_coef (r_coef),
                .exp        (cell_exp[g]),
                .coef       (cell_coef[g]),
                .lt         (cell_lt[g]),
                .hit        (cell_hit[g]),
                .hit_coef   (cell_hit_coef[g])
            );
        end
    endgenerate

    always_comb
    begin
        hit_or = '0;
        for (int i = 0; i < MAX_TERMS; i++)
        begin
            hit_or = hit_or | cell_hit_coef[i];
        end
    end

    assign sum       = {match_reg[31], match_reg} + {c_reg[31], c_reg};
    assign slot_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        k_next      = k_reg;
        status_next = status_reg;
        ctrl.cmd    = CMD_HOLD;
        ctrl.coef   = c_reg;
        out_load    = 1'b0;
        out_next    = '{out_exponent: 16'd0, out_coefficient: 32'sd0,
                        last_term: 1'b1, status: status_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.data.operation)
                        OP_CLEAR:
                        begin
                            count_next  = '0;
                            status_next = ST_OK;
                            state_next  = S_RESP;
                        end
                        OP_ADD:
                        begin
                            state_next = S_SEARCH;
                        end
                        OP_READ:
                        begin
                            k_next = '0;
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                ctrl.cmd   = CMD_SEARCH;
                state_next = S_MATCH;
            end
            S_MATCH:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                state_next  = S_RESP;
                status_next = ST_OK;
                if (any_reg)
                begin
                    ctrl.cmd = CMD_UPDATE;
                    if (sum > 33'sd2147483647)
                    begin
                        ctrl.coef   = 32'sh7FFFFFFF;
                        status_next = ST_SAT;
                    end
                    else if (sum < -33'sd2147483648)
                    begin
                        ctrl.coef   = 32'sh80000000;
                        status_next = ST_SAT;
                    end
                    else if (sum == '0)
                    begin
                        ctrl.cmd    = CMD_REMOVE;
                        count_next  = count_reg - CW'(1);
                        status_next = ST_CANCEL;
                    end
                    else
                    begin
                        ctrl.coef = sum[31:0];
                    end
                end
                else if (c_reg != '0)
                begin
                    if (count_reg == CW'(MAX_TERMS))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctrl.cmd   = CMD_INSERT;
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            S_RESP:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                if (CW'(k_reg) < count_reg)
                begin
                    if (slot_free)
                    begin
                        out_load = 1'b1;
                        out_next = '{out_exponent: out_exp_wide[15:0],
                                     out_coefficient: cell_coef[0],
                                     last_term: (CW'(k_reg) + CW'(1) == count_reg),
                                     status: ST_OK};
                        ctrl.cmd = CMD_ROTATE;
                    end
                end
                else
                begin
                    ctrl.cmd = CMD_ROTATE;
                end
                if (ctrl.cmd == CMD_ROTATE)
                begin
                    k_next = k_reg + KW'(1);
                    if (k_reg == KW'(MAX_TERMS - 1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            k_reg     <= k_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        if (accept)
        begin
            op_reg <= req.data.operation;
            e_reg  <= in_exp_wide[EXP_WIDTH-1:0];
            c_reg  <= req.data.term_coefficient;
        end
        if (state_reg == S_MATCH)
        begin
            match_reg <= hit_or;
            any_reg   <= |cell_hit;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_TERMS))
        else $error("term count above capacity");

    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MATCH) |-> $onehot0(cell_hit))
        else $error("exponent found in more than one cell");

    a_lt_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MATCH) |-> ((cell_lt & (cell_lt + MAX_TERMS'(1))) == '0))
        else $error("cells below search exponent not a prefix");

    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ($past(state_reg) == S_APPLY || $past(state_reg) == S_IDLE))
        else $error("term count changed outside clear or apply");

    a_read_op: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (op_reg == OP_READ))
        else $error("read sequence without read request");

endmodule
